### src/varint_delta_coordinate_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the varint delta coordinate decoder.
// Each macro checks one implication on the rising clock edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VARINT_DELTA_COORDINATE_DECODER_CORE_MACROS_SVH
`define VARINT_DELTA_COORDINATE_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VDCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VDCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/vdcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdcd_pkg
// Types and constants shared by the varint delta coordinate decoder modules.
// ----------------------------------------------------------------------------
package vdcd_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int RESULT_WIDTH        = 64;
   localparam int BYTE_WIDTH          = 8;
   localparam int GROUP_BITS          = 7;
   localparam int FIRST_GROUP_BITS    = 6;
   localparam int CONT_BIT            = 7;
   localparam int SIGN_BIT            = 6;
   localparam int SHIFT_WIDTH         = 7;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_MAX = 7'd127;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_UNSIGNED = 2'd0;
   localparam mode_type MODE_SIGNED   = 2'd1;
   localparam mode_type MODE_DELTA    = 2'd2;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  record_start;
   } req_payload_type;

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] decoded_value;
      logic                    axis_y;
      logic                    overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic                   in_progress;
      logic                   negative;
      logic                   overflowed;
      logic [SHIFT_WIDTH-1:0] shift_position;
   } value_ctrl_type;

endpackage
`default_nettype wire

### src/vdcd_value_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdcd_value_unit
// Merges one stream byte into the partly decoded value and its flags.
// ----------------------------------------------------------------------------
module vdcd_value_unit #(
   parameter int VALUE_WIDTH = vdcd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  vdcd_pkg::mode_type                  mode,
   input  logic [vdcd_pkg::BYTE_WIDTH-1:0]     data_byte,
   input  vdcd_pkg::value_ctrl_type            cur_ctrl,
   input  logic [VALUE_WIDTH-1:0]              cur_partial,
   output vdcd_pkg::value_ctrl_type            next_ctrl,
   output logic [VALUE_WIDTH-1:0]              next_partial
);
   import vdcd_pkg::*;

   logic [GROUP_BITS-1:0]             chunk;
   logic [VALUE_WIDTH+GROUP_BITS-1:0] shifted;
   logic [SHIFT_WIDTH:0]              shift_sum;
   logic                              in_range;
   logic                              signed_first;

   assign chunk        = data_byte[GROUP_BITS-1:0];
   assign signed_first = (mode inside {MODE_SIGNED, MODE_DELTA});
   assign shifted      = {{VALUE_WIDTH{1'b0}}, chunk} << cur_ctrl.shift_position;
   assign shift_sum    = {1'b0, cur_ctrl.shift_position} + (SHIFT_WIDTH+1)'(GROUP_BITS);
   assign in_range     = {1'b0, cur_ctrl.shift_position} < (SHIFT_WIDTH+1)'(VALUE_WIDTH);

   always_comb begin
      next_ctrl    = cur_ctrl;
      next_partial = cur_partial;
      if (!cur_ctrl.in_progress) begin
         next_ctrl.in_progress = 1'b1;
         next_ctrl.overflowed  = 1'b0;
         if (signed_first) begin
            next_ctrl.negative       = data_byte[SIGN_BIT];
            next_partial             = VALUE_WIDTH'(data_byte[FIRST_GROUP_BITS-1:0]);
            next_ctrl.shift_position = SHIFT_WIDTH'(FIRST_GROUP_BITS);
         end else begin
            next_ctrl.negative       = 1'b0;
            next_partial             = VALUE_WIDTH'(chunk);
            next_ctrl.shift_position = SHIFT_WIDTH'(GROUP_BITS);
         end
      end else begin
         if (in_range) begin
            if (|shifted[VALUE_WIDTH+GROUP_BITS-1:VALUE_WIDTH]) begin
               next_ctrl.overflowed = 1'b1;
            end
            next_partial = cur_partial | shifted[VALUE_WIDTH-1:0];
         end else if (|chunk) begin
            next_ctrl.overflowed = 1'b1;
         end
         next_ctrl.shift_position = (shift_sum > {1'b0, SHIFT_MAX}) ? SHIFT_MAX
                                                                   : shift_sum[SHIFT_WIDTH-1:0];
      end
   end

endmodule
`default_nettype wire

### src/varint_delta_coordinate_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// varint_delta_coordinate_decoder_core
// Byte-serial varint decoder with sign-magnitude and delta-pair modes.
// ----------------------------------------------------------------------------
// The block takes one byte per transfer and can accept a byte in every cycle
// unless a finished value waits for a stalled output register. A byte is held
// in the input register, where the group merge, negation and running-sum add
// are done, and the result of a byte with bit 7 clear is then held in the
// output register until it is taken. Bytes with bit 7 set only update the
// decoder state and give no result. The mode register is to be written only
// while no byte is in flight.
// ----------------------------------------------------------------------------
`include "varint_delta_coordinate_decoder_core_macros.svh"

module varint_delta_coordinate_decoder_core #(
   parameter int VALUE_WIDTH = vdcd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  vdcd_pkg::mode_type        csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  vdcd_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output vdcd_pkg::rsp_payload_type rsp_payload
);
   import vdcd_pkg::*;

   mode_type                mode_ff;
   logic                    in_valid_ff, in_valid_in;
   req_payload_type         in_data_ff;
   value_ctrl_type          ctrl_ff, ctrl_in;
   logic [VALUE_WIDTH-1:0]  partial_ff, partial_in;
   logic                    next_axis_ff, next_axis_in;
   logic [RESULT_WIDTH-1:0] sum_x_ff, sum_x_in;
   logic [RESULT_WIDTH-1:0] sum_y_ff, sum_y_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_data_ff;

   value_ctrl_type          eff_ctrl, merged_ctrl;
   logic [VALUE_WIDTH-1:0]  eff_partial, merged_partial;
   logic                    eff_axis;
   logic [RESULT_WIDTH-1:0] eff_sum_x, eff_sum_y;
   logic [RESULT_WIDTH-1:0] magnitude, addend, base, result;
   logic                    delta_mode, emit, out_free, advance, req_transfer;

   assign eff_ctrl    = in_data_ff.record_start ? '0 : ctrl_ff;
   assign eff_partial = in_data_ff.record_start ? '0 : partial_ff;
   assign eff_axis    = in_data_ff.record_start ? 1'b0 : next_axis_ff;
   assign eff_sum_x   = in_data_ff.record_start ? '0 : sum_x_ff;
   assign eff_sum_y   = in_data_ff.record_start ? '0 : sum_y_ff;

   vdcd_value_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_value_unit (
      .mode        (mode_ff),
      .data_byte   (in_data_ff.data_byte),
      .cur_ctrl    (eff_ctrl),
      .cur_partial (eff_partial),
      .next_ctrl   (merged_ctrl),
      .next_partial(merged_partial)
   );

   assign delta_mode = (mode_ff == MODE_DELTA);
   assign magnitude  = RESULT_WIDTH'(merged_partial);
   assign addend     = magnitude ^ {RESULT_WIDTH{merged_ctrl.negative}};
   assign base       = !delta_mode ? '0 : (eff_axis ? eff_sum_y : eff_sum_x);
   assign result     = base + addend + RESULT_WIDTH'(merged_ctrl.negative);

   assign emit         = !in_data_ff.data_byte[CONT_BIT];
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = in_valid_ff && (!emit || out_free);
   assign req_stall    = in_valid_ff && !advance;
   assign req_transfer = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      ctrl_in      = ctrl_ff;
      partial_in   = partial_ff;
      next_axis_in = next_axis_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      if (advance) begin
         next_axis_in = eff_axis;
         sum_x_in     = eff_sum_x;
         sum_y_in     = eff_sum_y;
         if (emit) begin
            ctrl_in    = '0;
            partial_in = '0;
            if (delta_mode) begin
               next_axis_in = !eff_axis;
               if (eff_axis) begin
                  sum_y_in = result;
               end else begin
                  sum_x_in = result;
               end
            end
         end else begin
            ctrl_in    = merged_ctrl;
            partial_in = merged_partial;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UNSIGNED;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         partial_ff   <= '0;
         next_axis_ff <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            mode_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctrl_ff      <= ctrl_in;
         partial_ff   <= partial_in;
         next_axis_ff <= next_axis_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_data_ff <= req_payload;
      end
      if (advance && emit) begin
         rsp_data_ff.decoded_value <= result;
         rsp_data_ff.axis_y        <= delta_mode && eff_axis;
         rsp_data_ff.overflow      <= merged_ctrl.overflowed;
      end
   end

   `VDCD_ASSERT_NEXT(a_value_closes, clock, reset, advance && emit, !ctrl_ff.in_progress,
      "Decoder state still in progress after the last byte of a value.")
   `VDCD_ASSERT_SAME(a_idle_shift_zero, clock, reset, !ctrl_ff.in_progress,
      (ctrl_ff.shift_position == '0) && !ctrl_ff.overflowed && !ctrl_ff.negative,
      "Idle decoder holds a nonzero shift position or stale flags.")
   `VDCD_ASSERT_SAME(a_busy_shift_min, clock, reset, ctrl_ff.in_progress,
      ctrl_ff.shift_position >= SHIFT_WIDTH'(FIRST_GROUP_BITS),
      "Decoder in progress with a shift position below the first group.")
   `VDCD_ASSERT_SAME(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff),
      $past(advance && emit),
      "Result register became valid without a completed value.")

endmodule
`default_nettype wire

### verif/tb_varint_delta_coordinate_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Varint delta coordinate decoder testbench
// Drives bytes in random bursts while the result side stalls in stretches of
// its own. A tracker class decodes every accepted byte in all four modes,
// keeps the running x/y sums, and checks each result against its queue of
// expected values.
// ----------------------------------------------------------------------------
module tb_varint_delta_coordinate_decoder_core;
   import vdcd_pkg::*;

   localparam int VW = 64;
   localparam mode_type MODE_SPARE = 2'd3;
   localparam int RANDOM_BYTES = 1500;

   class coordinate_tracker;
      mode_type          mode;
      logic [63:0]       magnitude;
      int unsigned       bit_pos;
      bit                started;
      bit                sign_set;
      bit                dropped;
      bit                y_next;
      logic [63:0]       x_sum;
      logic [63:0]       y_sum;
      rsp_payload_type   pending_values[$];
      int                errors;

      function new();
         mode = MODE_UNSIGNED;
         x_sum = '0;
         y_sum = '0;
         y_next = 1'b0;
         errors = 0;
         restart_value();
      endfunction

      function void restart_value();
         magnitude = '0;
         bit_pos = 0;
         started = 1'b0;
         sign_set = 1'b0;
         dropped = 1'b0;
      endfunction

      function void set_mode(mode_type m);
         mode = m;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function void take_byte(req_payload_type item);
         logic [7:0]      b;
         logic [63:0]     grp;
         logic [63:0]     width_ones;
         logic [63:0]     value;
         rsp_payload_type res;
         b = item.data_byte;
         width_ones = {64{1'b1}} >> (64 - VW);
         if (item.record_start) begin
            restart_value();
            y_next = 1'b0;
            x_sum = '0;
            y_sum = '0;
         end
         if (!started) begin
            started = 1'b1;
            if (mode == MODE_SIGNED || mode == MODE_DELTA) begin
               sign_set = b[6];
               magnitude = {58'd0, b[5:0]};
               bit_pos = 6;
            end else begin
               sign_set = 1'b0;
               magnitude = {57'd0, b[6:0]};
               bit_pos = 7;
            end
         end else begin
            grp = {57'd0, b[6:0]};
            if (bit_pos >= VW) begin
               if (grp != 0) dropped = 1'b1;
            end else begin
               if (bit_pos + 7 > VW && (grp >> (VW - bit_pos)) != 0) dropped = 1'b1;
               magnitude = (magnitude | (grp << bit_pos)) & width_ones;
            end
            bit_pos = (bit_pos + 7 > 127) ? 127 : bit_pos + 7;
         end
         if (b[7]) return;
         value = sign_set ? 64'd0 - magnitude : magnitude;
         res.axis_y = 1'b0;
         if (mode == MODE_DELTA) begin
            if (y_next) begin
               y_sum = y_sum + value;
               value = y_sum;
               res.axis_y = 1'b1;
            end else begin
               x_sum = x_sum + value;
               value = x_sum;
            end
            y_next = !y_next;
         end
         res.decoded_value = value;
         res.overflow = dropped;
         pending_values.push_back(res);
         restart_value();
      endfunction

      function void check_value(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_values.size() == 0) begin
            flag($sformatf("Unexpected result: value %h axis %b overflow %b.",
                           got.decoded_value, got.axis_y, got.overflow));
            return;
         end
         want = pending_values.pop_front();
         if (got.decoded_value !== want.decoded_value || got.axis_y !== want.axis_y ||
             got.overflow !== want.overflow) begin
            flag($sformatf("Mismatch: expected value %h axis %b overflow %b, got %h %b %b.",
                           want.decoded_value, want.axis_y, want.overflow,
                           got.decoded_value, got.axis_y, got.overflow));
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_write_en = 1'b0;
   mode_type        csr_write_data = MODE_UNSIGNED;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   coordinate_tracker tracker = new();
   int burst_left = 0;
   int random_sent = 0;
   int stall_left = 0;
   int stall_style = 0;

   varint_delta_coordinate_decoder_core #(.VALUE_WIDTH(VW)) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 80);
      end
      stall_left--;
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_left[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_value(rsp_payload);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic rs);
      req_payload_type item;
      int gap;
      item.data_byte = b;
      item.record_start = rs;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 20);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      tracker.take_byte(item);
      burst_left--;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_values.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= m;
      @(negedge clock);
      csr_write_en <= 1'b0;
      tracker.set_mode(m);
   endtask

   task automatic send_random_value();
      int len;
      int pick;
      int fill;
      logic [7:0] b;
      logic rs;
      pick = $urandom_range(0, 99);
      fill = $urandom_range(0, 5);
      if (pick < 70) len = $urandom_range(1, 3);
      else if (pick < 90) len = $urandom_range(4, 9);
      else len = $urandom_range(10, 12);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         if (fill == 0) b[6:0] = 7'h7F;
         else if (fill == 1) b[6:0] = 7'h00;
         b[7] = (i != len - 1);
         rs = (i == 0) ? ($urandom_range(0, 24) == 0) : ($urandom_range(0, 99) == 0);
         send_byte(b, rs);
         random_sent++;
      end
   endtask

   initial begin
      mode_type m;
      int phase_end;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_mode(MODE_UNSIGNED);
      send_byte(8'h00, 1'b1);
      send_byte(8'h7F, 1'b0);
      repeat (9) send_byte(8'hFF, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h05, 1'b0);
      drain();
      write_mode(MODE_SPARE);
      send_byte(8'h85, 1'b0);
      send_byte(8'h01, 1'b0);
      drain();
      write_mode(MODE_SIGNED);
      send_byte(8'h40, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hC1, 1'b0);
      drain();
      write_mode(MODE_UNSIGNED);
      send_byte(8'h02, 1'b0);
      drain();
      write_mode(MODE_DELTA);
      send_byte(8'h05, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h43, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h03, 1'b1);
      drain();

      while (random_sent < RANDOM_BYTES) begin
         case ($urandom_range(0, 5))
            0: m = MODE_UNSIGNED;
            1: m = MODE_SIGNED;
            2, 3: m = MODE_DELTA;
            4: m = MODE_SPARE;
            default: m = MODE_SIGNED;
         endcase
         write_mode(m);
         phase_end = random_sent + $urandom_range(100, 200);
         while (random_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
               random_sent++;
            end else begin
               send_random_value();
            end
         end
         drain();
      end

      if (tracker.pending_values.size() != 0) tracker.flag("Expected results left over.");
      if (tracker.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/vdcd_pkg.sv
src/vdcd_value_unit.sv
src/varint_delta_coordinate_decoder_core.sv
verif/tb_varint_delta_coordinate_decoder_core.sv
